FILE: rtl/core/mvsm_pkg.sv
// ============================================================================
// Mixer package
// Shared types, constants and the saturating add for the multi-voice mixer.
// ============================================================================
package mvsm_pkg;

    localparam int VOICES_DEF       = 16;
    localparam int SAMPLE_DEPTH_DEF = 65536;

    localparam int SMP_W       = 16;
    localparam int ADDR_W      = 16;
    localparam int POS_W       = 17;
    localparam int ID_W        = 8;
    localparam int CH_W        = 4;
    localparam int OP_W        = 3;
    localparam int EXT_W       = 25;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 40;

    localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_PLAY       = 3'd1,
        OP_STOP_ID    = 3'd2,
        OP_STOP_VOICE = 3'd3,
        OP_STOP_ALL   = 3'd4,
        OP_LOAD       = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_SEL,
        ST_TICK_VOICE,
        ST_TICK_MIX,
        ST_PLAY_SCAN,
        ST_PLAY_WRITE,
        ST_SID_RD,
        ST_SID_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] end_pos;
        logic [ID_W-1:0]  sound;
    } voice_t;

    function automatic logic signed [SMP_W-1:0] sat_add(
        input logic signed [SMP_W-1:0] a,
        input logic signed [SMP_W-1:0] b
    );
        logic [SMP_W:0] s;
        s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
        if (s[SMP_W] != s[SMP_W-1]) begin
            return s[SMP_W] ? SAT_MIN : SAT_MAX;
        end
        return s[SMP_W-1:0];
    endfunction

endpackage

FILE: rtl/core/multi_voice_saturating_mixer.sv
// ============================================================================
// Multi-voice saturating mixer
// Stereo sample mixer: voices read one sample store and are summed with
// 16-bit saturation onto an optional background frame.
// ============================================================================
// One transaction is taken at a time; s_axis_tready is high only while the
// sequencer is idle, and the result sits in an output register so the next
// transaction can be taken while it waits. A tick steps through the voices:
// an inactive voice is skipped, and for an active one the voice state RAM
// read, the sample store read and the shared saturating accumulate follow
// one another (a voice that has reached its end stops after the state read).
// Play scans the voices up to and including the first free one, or all of
// them when every voice is busy. Stop by id reads and compares every active
// voice, and every other operation goes straight to its result. The sample
// store needs no clearing after reset.
module multi_voice_saturating_mixer #(
    parameter int VOICES       = mvsm_pkg::VOICES_DEF,
    parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,      // bgm_enable
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // bgm_left, bgm_right, start_address, end_address, sound_id,
    // channel_index, sample_address, sample_left, sample_right, zero fill
    input  logic [mvsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [mvsm_pkg::OP_W-1:0]          s_axis_tuser,  // operation
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mix_left, mix_right, assigned_voice, zero fill
    output logic [mvsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import mvsm_pkg::*;

    localparam int VI_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VC_W    = $clog2(VOICES + 1);
    localparam int SA_W    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int VOICE_W = $bits(voice_t);
    localparam logic [VC_W-1:0]  VOICES_C = VC_W'(VOICES);
    localparam logic [7:0]       VOICES_E = 8'(VOICES);
    localparam logic [EXT_W-1:0] DEPTH_C  = EXT_W'(SAMPLE_DEPTH);

    state_t                   state_reg, state_next;
    logic [VC_W-1:0]          vidx_reg, vidx_next;
    logic [VOICES-1:0]        active_reg, active_next;
    logic signed [SMP_W-1:0]  acc_l_reg, acc_l_next;
    logic signed [SMP_W-1:0]  acc_r_reg, acc_r_next;
    logic [CH_W-1:0]          assigned_reg, assigned_next;
    logic [ADDR_W-1:0]        start_reg, start_next;
    logic [POS_W-1:0]         endp_reg, endp_next;
    logic [ID_W-1:0]          sound_reg, sound_next;
    logic                     in_range_reg, in_range_next;
    logic                     bgm_en_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic                     accept;
    op_t                      op_in;
    logic [VI_W-1:0]          vi;
    logic                     vidx_done;
    logic                     out_free;
    logic [7:0]               ch_ext;
    logic [7:0]               vidx_ext;
    logic [EXT_W-1:0]         saddr_ext;
    logic [EXT_W-1:0]         pos_ext;
    logic                     pos_in_range;
    voice_t                   voice_q;
    voice_t                   voice_wr_data;
    logic                     voice_wr_en;
    logic                     voice_rd_en;
    logic [VOICE_W-1:0]       voice_rd_data;
    logic                     smp_wr_en;
    logic                     smp_rd_en;
    logic [2*SMP_W-1:0]       smp_rd_data;
    logic signed [SMP_W-1:0]  smp_l;
    logic signed [SMP_W-1:0]  smp_r;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op_in         = op_t'(s_axis_tuser);
    assign vi            = vidx_reg[VI_W-1:0];
    assign vidx_done     = (vidx_reg == VOICES_C);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign ch_ext        = 8'(s_axis_tdata[76:73]);
    assign vidx_ext      = 8'(vidx_reg);
    assign saddr_ext     = EXT_W'(s_axis_tdata[92:77]);
    assign voice_q       = voice_t'(voice_rd_data);
    assign pos_ext       = EXT_W'(voice_q.pos);
    assign pos_in_range  = (pos_ext < DEPTH_C);
    assign smp_l         = in_range_reg ? signed'(smp_rd_data[31:16]) : '0;
    assign smp_r         = in_range_reg ? signed'(smp_rd_data[15:0]) : '0;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    mvsm_ram #(
        .WIDTH (VOICE_W),
        .DEPTH (VOICES),
        .AW    (VI_W)
    ) u_voice_ram (
        .clk     (clk),
        .wr_en   (voice_wr_en),
        .wr_addr (vi),
        .wr_data (voice_wr_data),
        .rd_en   (voice_rd_en),
        .rd_addr (vi),
        .rd_data (voice_rd_data)
    );

    mvsm_ram #(
        .WIDTH (2 * SMP_W),
        .DEPTH (SAMPLE_DEPTH),
        .AW    (SA_W)
    ) u_sample_ram (
        .clk     (clk),
        .wr_en   (smp_wr_en),
        .wr_addr (saddr_ext[SA_W-1:0]),
        .wr_data ({s_axis_tdata[108:93], s_axis_tdata[124:109]}),
        .rd_en   (smp_rd_en),
        .rd_addr (pos_ext[SA_W-1:0]),
        .rd_data (smp_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_TICK:    state_next = ST_TICK_SEL;
                        OP_PLAY:    state_next = ST_PLAY_SCAN;
                        OP_STOP_ID: state_next = ST_SID_RD;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_TICK_SEL:
            begin
                if (vidx_done)
                begin
                    state_next = ST_DONE;
                end
                else if (active_reg[vi])
                begin
                    state_next = ST_TICK_VOICE;
                end
            end
            ST_TICK_VOICE:
            begin
                if (voice_q.pos == voice_q.end_pos)
                begin
                    state_next = ST_TICK_SEL;
                end
                else
                begin
                    state_next = ST_TICK_MIX;
                end
            end
            ST_TICK_MIX:
            begin
                state_next = ST_TICK_SEL;
            end
            ST_PLAY_SCAN:
            begin
                if (vidx_done || !active_reg[vi])
                begin
                    state_next = ST_PLAY_WRITE;
                end
            end
            ST_PLAY_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_SID_RD:
            begin
                if (vidx_done)
                begin
                    state_next = ST_DONE;
                end
                else if (active_reg[vi])
                begin
                    state_next = ST_SID_CMP;
                end
            end
            ST_SID_CMP:
            begin
                state_next = ST_SID_RD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        vidx_next     = vidx_reg;
        active_next   = active_reg;
        acc_l_next    = acc_l_reg;
        acc_r_next    = acc_r_reg;
        assigned_next = assigned_reg;
        start_next    = start_reg;
        endp_next     = endp_reg;
        sound_next    = sound_reg;
        in_range_next = in_range_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        voice_wr_en   = 1'b0;
        voice_rd_en   = 1'b0;
        smp_wr_en     = 1'b0;
        smp_rd_en     = 1'b0;
        voice_wr_data = voice_q;
        voice_wr_data.pos = voice_q.pos + 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    vidx_next     = '0;
                    acc_l_next    = '0;
                    acc_r_next    = '0;
                    assigned_next = '0;
                    start_next    = s_axis_tdata[47:32];
                    endp_next     = s_axis_tdata[64:48];
                    sound_next    = s_axis_tdata[72:65];
                    case (op_in)
                        OP_TICK:
                        begin
                            if (bgm_en_reg)
                            begin
                                acc_l_next = signed'(s_axis_tdata[15:0]);
                                acc_r_next = signed'(s_axis_tdata[31:16]);
                            end
                        end
                        OP_STOP_VOICE:
                        begin
                            if (ch_ext < VOICES_E)
                            begin
                                active_next[ch_ext[VI_W-1:0]] = 1'b0;
                            end
                        end
                        OP_STOP_ALL:
                        begin
                            active_next = '0;
                        end
                        OP_LOAD:
                        begin
                            smp_wr_en = (saddr_ext < DEPTH_C);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK_SEL:
            begin
                if (!vidx_done)
                begin
                    if (active_reg[vi])
                    begin
                        voice_rd_en = 1'b1;
                    end
                    else
                    begin
                        vidx_next = vidx_reg + 1'b1;
                    end
                end
            end
            ST_TICK_VOICE:
            begin
                if (voice_q.pos == voice_q.end_pos)
                begin
                    active_next[vi] = 1'b0;
                    vidx_next       = vidx_reg + 1'b1;
                end
                else
                begin
                    smp_rd_en     = pos_in_range;
                    in_range_next = pos_in_range;
                end
            end
            ST_TICK_MIX:
            begin
                acc_l_next  = sat_add(acc_l_reg, smp_l);
                acc_r_next  = sat_add(acc_r_reg, smp_r);
                voice_wr_en = 1'b1;
                vidx_next   = vidx_reg + 1'b1;
            end
            ST_PLAY_SCAN:
            begin
                if (vidx_done)
                begin
                    vidx_next = '0;
                end
                else if (active_reg[vi])
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_PLAY_WRITE:
            begin
                voice_wr_en           = 1'b1;
                voice_wr_data.pos     = POS_W'(start_reg);
                voice_wr_data.end_pos = endp_reg;
                voice_wr_data.sound   = sound_reg;
                active_next[vi]       = 1'b1;
                assigned_next         = vidx_ext[CH_W-1:0];
            end
            ST_SID_RD:
            begin
                if (!vidx_done)
                begin
                    if (active_reg[vi])
                    begin
                        voice_rd_en = 1'b1;
                    end
                    else
                    begin
                        vidx_next = vidx_reg + 1'b1;
                    end
                end
            end
            ST_SID_CMP:
            begin
                if (voice_q.sound == sound_reg)
                begin
                    active_next[vi] = 1'b0;
                end
                vidx_next = vidx_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, assigned_reg, acc_r_reg, acc_l_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vidx_reg    <= '0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
            bgm_en_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vidx_reg    <= vidx_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                bgm_en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_l_reg    <= acc_l_next;
        acc_r_reg    <= acc_r_next;
        assigned_reg <= assigned_next;
        start_reg    <= start_next;
        endp_reg     <= endp_next;
        sound_reg    <= sound_next;
        in_range_reg <= in_range_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    a_vidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vidx_reg <= VOICES_C)
        else $error("voice counter ran past the last voice");

    a_play_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PLAY_WRITE |-> vidx_reg < VOICES_C)
        else $error("play writes a voice that does not exist");

    a_mix_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK_MIX |-> active_reg[vi])
        else $error("mixing a voice that is not active");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_free |=> m_axis_tvalid && s_axis_tready)
        else $error("finished transaction did not reach the output register");
`endif

endmodule

FILE: rtl/core/mvsm_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module mvsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Multi-voice saturating mixer testbench
// Drives ticks, plays, stops and sample loads through the input stream and
// checks every output frame against a cycle-free model of the mixer kept in
// a small scoreboard. A directed opening covers the saturation limits, sounds
// that start at or after their end and the unused operation codes. Random
// phases follow under both background settings, with random idling on both
// streams, one long receiver hold-off and one stretch with no idling.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvsm_pkg::*;

    localparam int VOICES       = VOICES_DEF;
    localparam int DEPTH        = SAMPLE_DEPTH_DEF;
    localparam int PERIOD       = 20;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 60;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [SMP_W-1:0] bgm_left;
        logic signed [SMP_W-1:0] bgm_right;
        logic [ADDR_W-1:0]       start_addr;
        logic [POS_W-1:0]        end_addr;
        logic [ID_W-1:0]         sound;
        logic [CH_W-1:0]         channel;
        logic [ADDR_W-1:0]       sample_addr;
        logic signed [SMP_W-1:0] sample_left;
        logic signed [SMP_W-1:0] sample_right;
    } mix_cmd_t;

    typedef struct {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
        logic [CH_W-1:0]         voice;
    } mix_frame_t;

    class mixer_scoreboard;
        logic             bgm_enable;
        bit               active [VOICES];
        logic [POS_W-1:0] pos [VOICES];
        logic [POS_W-1:0] stop_at [VOICES];
        logic [ID_W-1:0]  sound [VOICES];
        logic [31:0]      store [DEPTH];
        bit               written [DEPTH];
        mix_frame_t       expected_frames [$];
        int               errors;
        int               items;
        int               frames;
        int               clipped;
        int               full_plays;
        int               op_count [8];

        function new();
            bgm_enable = 1'b0;
            clear_voices();
        endfunction

        function void clear_voices();
            for (int i = 0; i < VOICES; i++) begin
                active[i]  = 1'b0;
                pos[i]     = '0;
                stop_at[i] = '0;
                sound[i]   = '0;
            end
        endfunction

        function int busy_voices();
            int n;
            n = 0;
            for (int i = 0; i < VOICES; i++) n += active[i];
            return n;
        endfunction

        function int clip16(int v);
            if (v > int'(SAT_MAX)) return int'(SAT_MAX);
            if (v < int'(SAT_MIN)) return int'(SAT_MIN);
            return v;
        endfunction

        function mix_frame_t predict_frame(mix_cmd_t c);
            mix_frame_t              f;
            int                      acc_l;
            int                      acc_r;
            int                      t;
            int                      slot;
            bit                      hit;
            logic signed [SMP_W-1:0] sl;
            logic signed [SMP_W-1:0] sr;
            logic [31:0]             word;
            f.left  = '0;
            f.right = '0;
            f.voice = '0;
            case (c.op)
                OP_TICK: begin
                    acc_l = 0;
                    acc_r = 0;
                    hit   = 1'b0;
                    if (bgm_enable) begin
                        acc_l = c.bgm_left;
                        acc_r = c.bgm_right;
                    end
                    for (int i = 0; i < VOICES; i++) begin
                        if (active[i]) begin
                            if (pos[i] == stop_at[i]) begin
                                active[i] = 1'b0;
                            end
                            else begin
                                sl = '0;
                                sr = '0;
                                if (!pos[i][POS_W-1]) begin
                                    word = store[pos[i][ADDR_W-1:0]];
                                    sl   = word[31:16];
                                    sr   = word[15:0];
                                end
                                t     = acc_l + sl;
                                acc_l = clip16(t);
                                hit   = hit | (acc_l != t);
                                t     = acc_r + sr;
                                acc_r = clip16(t);
                                hit   = hit | (acc_r != t);
                                pos[i] = pos[i] + 1'b1;
                            end
                        end
                    end
                    f.left  = acc_l[SMP_W-1:0];
                    f.right = acc_r[SMP_W-1:0];
                    if (hit) clipped++;
                end
                OP_PLAY: begin
                    slot = 0;
                    if (busy_voices() == VOICES) full_plays++;
                    for (int i = VOICES - 1; i >= 0; i--) begin
                        if (!active[i]) slot = i;
                    end
                    active[slot]  = 1'b1;
                    pos[slot]     = {1'b0, c.start_addr};
                    stop_at[slot] = c.end_addr;
                    sound[slot]   = c.sound;
                    f.voice       = slot[CH_W-1:0];
                end
                OP_STOP_ID: begin
                    for (int i = 0; i < VOICES; i++) begin
                        if (sound[i] == c.sound) active[i] = 1'b0;
                    end
                end
                OP_STOP_VOICE: begin
                    if (c.channel < VOICES) active[c.channel] = 1'b0;
                end
                OP_STOP_ALL: begin
                    clear_voices();
                end
                OP_LOAD: begin
                    store[c.sample_addr]   = {c.sample_left, c.sample_right};
                    written[c.sample_addr] = 1'b1;
                end
                default: begin
                end
            endcase
            return f;
        endfunction

        function void note_item(mix_cmd_t c);
            expected_frames.push_back(predict_frame(c));
            items++;
            op_count[c.op]++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at frame %0d: %s", frames, msg);
        endtask

        task check_frame(logic [OUT_TDATA_W-1:0] d);
            mix_frame_t e;
            if (expected_frames.size() == 0) begin
                report_mismatch("frame arrived with nothing expected");
            end
            else begin
                e = expected_frames.pop_front();
                frames++;
                if (d[15:0] !== e.left)
                    report_mismatch($sformatf("mix_left %0d, expected %0d",
                                              $signed(d[15:0]), e.left));
                if (d[31:16] !== e.right)
                    report_mismatch($sformatf("mix_right %0d, expected %0d",
                                              $signed(d[31:16]), e.right));
                if (d[35:32] !== e.voice)
                    report_mismatch($sformatf("assigned_voice %0d, expected %0d",
                                              d[35:32], e.voice));
            end
        endtask
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data      = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    mixer_scoreboard sb;
    int              cycles     = 0;
    int              hold_left  = 0;
    bit              hold_done  = 1'b0;
    int              bgm_writes = 0;

    multi_voice_saturating_mixer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d frames outstanding.",
                     cycles, sb.expected_frames.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_frame(m_axis_tdata);
            if (!hold_done && sb.frames >= 300) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sb.frames >= 450 && sb.frames < 570) begin
                m_axis_tready <= 1'b1;
            end
            else begin
                m_axis_tready <= ($urandom_range(99, 0) >= 18);
            end
        end
    end

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(7, 0))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return 16'sd30000;
            3:       return -16'sd30000;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(9, 0) < 7) return ID_W'($urandom_range(7, 0));
        return ID_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] span_end(logic [ADDR_W-1:0] start, int len);
        int s;
        s = start + len;
        if (s > DEPTH) s = DEPTH;
        return POS_W'(s);
    endfunction

    function automatic mix_cmd_t random_cmd(logic [OP_W-1:0] op);
        mix_cmd_t c;
        c.op           = op;
        c.bgm_left     = SMP_W'($urandom);
        c.bgm_right    = SMP_W'($urandom);
        c.start_addr   = ADDR_W'($urandom);
        c.end_addr     = POS_W'($urandom_range(DEPTH, 0));
        c.sound        = ID_W'($urandom);
        c.channel      = CH_W'($urandom);
        c.sample_addr  = ADDR_W'($urandom);
        c.sample_left  = SMP_W'($urandom);
        c.sample_right = SMP_W'($urandom);
        return c;
    endfunction

    task automatic push_cmd(input mix_cmd_t c);
        while (!(sb.items >= 450 && sb.items < 570) && $urandom_range(99, 0) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {3'b000, c.sample_right, c.sample_left, c.sample_addr, c.channel,
                          c.sound, c.end_addr, c.start_addr, c.bgm_right, c.bgm_left};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_item(c);
    endtask

    task automatic load_cmd(input logic [ADDR_W-1:0] addr,
                            input logic signed [SMP_W-1:0] l,
                            input logic signed [SMP_W-1:0] r);
        mix_cmd_t c;
        c              = random_cmd(OP_LOAD);
        c.sample_addr  = addr;
        c.sample_left  = l;
        c.sample_right = r;
        push_cmd(c);
    endtask

    // Every voice that will read the store on this tick gets its entry
    // written first, so no tick ever reads an entry that was never loaded.
    task automatic tick_cmd(input logic signed [SMP_W-1:0] l,
                            input logic signed [SMP_W-1:0] r);
        mix_cmd_t c;
        for (int i = 0; i < VOICES; i++) begin
            if (sb.active[i] && sb.pos[i] != sb.stop_at[i] && !sb.pos[i][POS_W-1]
                && !sb.written[sb.pos[i][ADDR_W-1:0]])
                load_cmd(sb.pos[i][ADDR_W-1:0], pick_sample(), pick_sample());
        end
        c           = random_cmd(OP_TICK);
        c.bgm_left  = l;
        c.bgm_right = r;
        push_cmd(c);
    endtask

    task automatic play_cmd(input logic [ADDR_W-1:0] start,
                            input logic [POS_W-1:0] stop,
                            input logic [ID_W-1:0] id);
        mix_cmd_t c;
        c            = random_cmd(OP_PLAY);
        c.start_addr = start;
        c.end_addr   = stop;
        c.sound      = id;
        push_cmd(c);
    endtask

    task automatic op_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [CH_W-1:0] ch);
        mix_cmd_t c;
        c         = random_cmd(op);
        c.sound   = id;
        c.channel = ch;
        push_cmd(c);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_frames.size() != 0) @(posedge clk);
    endtask

    task automatic write_bgm(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.bgm_enable = en;
        bgm_writes++;
    endtask

    task automatic run_random(input int count);
        int               target;
        int               r;
        int               len;
        logic [ADDR_W-1:0] start;
        target = sb.items + count;
        while (sb.items < target) begin
            r = $urandom_range(99, 0);
            if (r < 22) begin
                start = ADDR_W'($urandom);
                len   = $urandom_range(24, 1);
                for (int a = 0; a < len && start + a < DEPTH; a++)
                    load_cmd(ADDR_W'(start + a), pick_sample(), pick_sample());
                play_cmd(start, span_end(start, len), pick_id());
            end
            else if (r < 55) begin
                tick_cmd(pick_sample(), pick_sample());
            end
            else if (r < 65) begin
                repeat ($urandom_range(6, 2)) tick_cmd(pick_sample(), pick_sample());
            end
            else if (r < 71) begin
                op_cmd(OP_STOP_ID, pick_id(), CH_W'($urandom));
            end
            else if (r < 77) begin
                op_cmd(OP_STOP_VOICE, ID_W'($urandom), CH_W'($urandom));
            end
            else if (r < 79) begin
                op_cmd(OP_STOP_ALL, ID_W'($urandom), CH_W'($urandom));
            end
            else if (r < 85) begin
                start = ADDR_W'($urandom);
                if ($urandom_range(4, 0) == 0)
                    play_cmd(start, POS_W'($urandom_range(DEPTH, 0)), pick_id());
                else
                    play_cmd(start, span_end(start, $urandom_range(40, 0)), pick_id());
            end
            else if (r < 89) begin
                load_cmd(ADDR_W'($urandom), pick_sample(), pick_sample());
            end
            else if (r < 91) begin
                op_cmd($urandom_range(1, 0) ? OP_SPARE_HI : OP_SPARE_LO,
                       ID_W'($urandom), CH_W'($urandom));
            end
            else if (r < 93) begin
                while (sb.busy_voices() < VOICES) begin
                    start = ADDR_W'($urandom);
                    play_cmd(start, span_end(start, 30), pick_id());
                end
                start = ADDR_W'($urandom);
                play_cmd(start, span_end(start, 30), pick_id());
            end
            else if (r < 97) begin
                play_cmd(ADDR_W'($urandom_range(DEPTH - 1, DEPTH - 8)),
                         POS_W'($urandom_range(6, 0)), pick_id());
            end
            else begin
                tick_cmd(SMP_W'($urandom), SMP_W'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_bgm(1'b1);
        load_cmd(16'd0, SAT_MAX, SAT_MIN);
        load_cmd(16'hFFFF, SAT_MIN, SAT_MAX);
        load_cmd(16'd1, 16'sd1, -16'sd1);
        tick_cmd(SAT_MAX, SAT_MIN);
        play_cmd(16'd0, 17'd2, 8'hFF);
        play_cmd(16'hFFFF, 17'd0, 8'h00);
        play_cmd(16'd5, 17'd5, 8'd7);
        tick_cmd(SAT_MAX, SAT_MIN);
        tick_cmd(SAT_MIN, SAT_MAX);
        tick_cmd(16'sd0, 16'sd0);
        op_cmd(OP_STOP_VOICE, 8'd0, 4'd15);
        op_cmd(OP_STOP_VOICE, 8'd0, 4'd1);
        op_cmd(OP_STOP_ID, 8'hFF, 4'd0);
        op_cmd(OP_SPARE_LO, 8'd0, 4'd0);
        op_cmd(OP_SPARE_HI, 8'd0, 4'd0);
        op_cmd(OP_STOP_ALL, 8'd0, 4'd0);
        drain();

        write_bgm(1'b0);
        play_cmd(16'd0, 17'h10000, 8'd3);
        tick_cmd(SAT_MAX, SAT_MAX);
        op_cmd(OP_STOP_ID, 8'd3, 4'd0);
        tick_cmd(SAT_MIN, SAT_MIN);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_bgm(ph % 3 != 0);
            run_random(105);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions: %0d ticks, %0d plays, %0d stops, %0d loads.",
                 sb.items, sb.op_count[OP_TICK], sb.op_count[OP_PLAY],
                 sb.op_count[OP_STOP_ID] + sb.op_count[OP_STOP_VOICE]
                 + sb.op_count[OP_STOP_ALL], sb.op_count[OP_LOAD]);
        $display("%0d frames clipped, %0d plays with every voice busy, %0d bgm writes.",
                 sb.clipped, sb.full_plays, bgm_writes);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
